>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker file bdio_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: implication");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next cycle");

`endif

>>> rtl/bdio_pkg.sv
// ----------------------------------------------------------------------------
// bdio_pkg
// Types and constants shared by the bus decode and I/O register block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdio_pkg;

    localparam int DRIVE_COUNT = 8;
    localparam logic [24:0] RAM_BYTES = 25'd8388608;

    localparam logic [23:0] IO_BASE  = 24'h00FE00;
    localparam logic [23:0] IO_LIMIT = 24'h00FF00;
    localparam logic [7:0]  BANK_VRAM = 8'hFE;
    localparam logic [7:0]  BANK_WIN  = 8'hFF;

    localparam logic [7:0] KEY_EMPTY   = 8'hFF;
    localparam logic [7:0] WINDOW_INIT = 8'h34;
    localparam logic [7:0] MASK_INIT   = 8'h01;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_TICK  = 2'd2,
        K_KEY   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RG_RAM  = 3'd0,
        RG_VRAM = 3'd1,
        RG_IO   = 3'd2,
        RG_WIN  = 3'd3,
        RG_BAD  = 3'd4
    } t_region;

    typedef enum logic [2:0] {
        TGT_RAM  = 3'd0,
        TGT_VRAM = 3'd1,
        TGT_IO   = 3'd2,
        TGT_EXT  = 3'd3,
        TGT_BAD  = 3'd4
    } t_target;

    typedef enum logic [3:0] {
        XOP_NONE     = 4'd0,
        XOP_CON_OUT  = 4'd1,
        XOP_CON_IN   = 4'd2,
        XOP_CON_STAT = 4'd3,
        XOP_DISK_RD  = 4'd4,
        XOP_DISK_WR  = 4'd5,
        XOP_SEEK     = 4'd6,
        XOP_EXIT     = 4'd7,
        XOP_TRACE    = 4'd8
    } t_xop;

    typedef struct packed {
        t_kind       kind;
        t_region     region;
        logic [23:0] maddr;
        logic [7:0]  io_reg;
        logic [7:0]  data;
        logic        dbg;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        t_target     target;
        logic [23:0] maddr;
        logic [7:0]  rdata;
        t_xop        op;
        logic [24:0] val;
        logic        irq;
        logic        fault;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/bdio_front.sv
// ----------------------------------------------------------------------------
// bdio_front
// Classifies an incoming item by command and address region.
// ----------------------------------------------------------------------------
`default_nettype none

module bdio_front (
    input  wire logic [1:0]     i_command,
    input  wire logic [23:0]    i_address,
    input  wire logic [7:0]     i_write_data,
    input  wire logic           i_debug_access,
    output bdio_pkg::t_cmd      o_cmd
);

    always_comb begin
        o_cmd.kind   = bdio_pkg::t_kind'(i_command);
        o_cmd.data   = i_write_data;
        o_cmd.io_reg = i_address[7:0];
        // Debug only matters on reads.
        o_cmd.dbg    = i_debug_access && (i_command == bdio_pkg::K_READ);
        o_cmd.maddr  = '0;
        // Bank FF is resolved later against the window register.
        if (i_address[23:16] == bdio_pkg::BANK_WIN) begin
            o_cmd.region = bdio_pkg::RG_WIN;
        end else if (i_address[23:16] == bdio_pkg::BANK_VRAM) begin
            o_cmd.region = bdio_pkg::RG_VRAM;
            o_cmd.maddr  = {10'd0, i_address[13:0]};
        end else if (i_address >= bdio_pkg::IO_BASE && i_address < bdio_pkg::IO_LIMIT) begin
            o_cmd.region = bdio_pkg::RG_IO;
        end else if ({1'b0, i_address} < bdio_pkg::RAM_BYTES) begin
            o_cmd.region = bdio_pkg::RG_RAM;
            o_cmd.maddr  = i_address;
        end else begin
            o_cmd.region = bdio_pkg::RG_BAD;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bdio_queue.sv
// ----------------------------------------------------------------------------
// bdio_queue
// Short command queue between the classifying front and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdio_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bdio_pkg::t_cmd i_cmd,
    output logic                o_full,
    output bdio_pkg::t_head     o_head,
    input  wire logic           i_take
);

    bdio_pkg::t_cmd                       r_mem [bdio_pkg::CMD_DEPTH];
    logic [bdio_pkg::CMD_PTR_W-1:0]       r_wr_ptr;
    logic [bdio_pkg::CMD_PTR_W-1:0]       r_rd_ptr;
    logic [bdio_pkg::CMD_CNT_W-1:0]       r_cnt;
    logic                                 wr_en;
    logic                                 rd_en;

    localparam logic [bdio_pkg::CMD_PTR_W-1:0] PTR_LAST =
        bdio_pkg::CMD_PTR_W'(bdio_pkg::CMD_DEPTH - 1);
    localparam logic [bdio_pkg::CMD_CNT_W-1:0] CNT_FULL =
        bdio_pkg::CMD_CNT_W'(bdio_pkg::CMD_DEPTH);

    assign o_full      = (r_cnt == CNT_FULL);
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_take && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bdio_back.sv
// ----------------------------------------------------------------------------
// bdio_back
// Executes queued items against the I/O registers and buffers the results.
// ----------------------------------------------------------------------------
`default_nettype none

module bdio_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bdio_pkg::t_head i_head,
    output logic                 o_take,
    input  wire logic            i_cfg_we,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output bdio_pkg::t_res       o_res
);

    localparam logic [7:0] IO_TICK    = 8'h10;
    localparam logic [7:0] IO_WINDOW  = 8'h11;
    localparam logic [7:0] IO_CON     = 8'h20;
    localparam logic [7:0] IO_CSTAT   = 8'h21;
    localparam logic [7:0] IO_KEY     = 8'h22;
    localparam logic [7:0] IO_KHELD   = 8'h23;
    localparam logic [7:0] IO_DSEL    = 8'h30;
    localparam logic [7:0] IO_BLK_HI  = 8'h31;
    localparam logic [7:0] IO_BLK_LO  = 8'h32;
    localparam logic [7:0] IO_SEEK    = 8'h33;
    localparam logic [7:0] IO_DDATA   = 8'h34;
    localparam logic [7:0] IO_DSTAT   = 8'h35;
    localparam logic [7:0] IO_EXIT    = 8'h40;
    localparam logic [7:0] IO_TRACE   = 8'h41;
    localparam logic [7:0] EXIT_MAGIC = 8'hA5;
    localparam logic [1:0] STAT_NODISK = 2'd2;
    localparam logic [7:0] DRV_LIMIT  = 8'(bdio_pkg::DRIVE_COUNT);

    logic [7:0]  r_mask;
    logic [7:0]  r_tick,   n_tick;
    logic        r_irq,    n_irq;
    logic [7:0]  r_window, n_window;
    logic [2:0]  r_dsel,   n_dsel;
    logic [15:0] r_block,  n_block;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_key,    n_key;

    bdio_pkg::t_res res;
    bdio_pkg::t_cmd cmd;
    logic [7:0]     io_reg;
    logic           sel_ok;
    logic           data_ok;

    bdio_pkg::t_res r_buf [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           fire;
    logic           pop_ok;

    assign cmd     = i_head.cmd;
    assign fire    = i_head.valid && (r_cnt != 2'd2);
    assign o_take  = fire;
    assign o_empty = (r_cnt == 2'd0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_res   = r_buf[r_rd_ptr];

    assign io_reg  = (cmd.region == bdio_pkg::RG_WIN) ? r_window : cmd.io_reg;
    assign sel_ok  = ({5'd0, r_dsel} < DRV_LIMIT) && r_mask[r_dsel];
    assign data_ok = (cmd.data < DRV_LIMIT) && r_mask[cmd.data[2:0]];

    always_comb begin
        n_tick   = r_tick;
        n_irq    = r_irq;
        n_window = r_window;
        n_dsel   = r_dsel;
        n_block  = r_block;
        n_status = r_status;
        n_key    = r_key;

        res.target = bdio_pkg::TGT_RAM;
        res.maddr  = '0;
        res.rdata  = 8'hFF;
        res.op     = bdio_pkg::XOP_NONE;
        res.val    = '0;
        res.fault  = 1'b0;

        unique case (cmd.kind)
            bdio_pkg::K_TICK: begin
                n_tick = r_tick + 8'd1;
                n_irq  = 1'b1;
            end
            bdio_pkg::K_KEY: begin
                n_key = cmd.data;
            end
            default: begin
                unique case (cmd.region)
                    bdio_pkg::RG_RAM: begin
                        res.target = bdio_pkg::TGT_RAM;
                        res.maddr  = cmd.maddr;
                    end
                    bdio_pkg::RG_VRAM: begin
                        res.target = bdio_pkg::TGT_VRAM;
                        res.maddr  = cmd.maddr;
                    end
                    bdio_pkg::RG_IO, bdio_pkg::RG_WIN: begin
                        res.target = bdio_pkg::TGT_IO;
                        if (cmd.kind == bdio_pkg::K_WRITE) begin
                            unique case (io_reg)
                                IO_WINDOW: n_window = cmd.data;
                                IO_CON: begin
                                    res.target = bdio_pkg::TGT_EXT;
                                    res.op     = bdio_pkg::XOP_CON_OUT;
                                    res.val    = {17'd0, cmd.data};
                                end
                                IO_DSEL: begin
                                    if (data_ok) begin
                                        n_dsel = cmd.data[2:0];
                                    end else begin
                                        n_status = STAT_NODISK;
                                    end
                                end
                                IO_BLK_HI: n_block = {cmd.data, r_block[7:0]};
                                IO_BLK_LO: n_block = {r_block[15:8], cmd.data};
                                IO_SEEK: begin
                                    if (sel_ok) begin
                                        n_status   = 2'd0;
                                        res.target = bdio_pkg::TGT_EXT;
                                        res.op     = bdio_pkg::XOP_SEEK;
                                        res.val    = {r_block, 9'd0};
                                    end else begin
                                        n_status = STAT_NODISK;
                                    end
                                end
                                IO_DDATA: begin
                                    if (sel_ok) begin
                                        res.target = bdio_pkg::TGT_EXT;
                                        res.op     = bdio_pkg::XOP_DISK_WR;
                                        res.val    = {17'd0, cmd.data};
                                    end else begin
                                        n_status = STAT_NODISK;
                                    end
                                end
                                IO_EXIT: begin
                                    if (cmd.data == EXIT_MAGIC) begin
                                        res.target = bdio_pkg::TGT_EXT;
                                        res.op     = bdio_pkg::XOP_EXIT;
                                    end else begin
                                        res.target = bdio_pkg::TGT_BAD;
                                        res.fault  = 1'b1;
                                    end
                                end
                                IO_TRACE: begin
                                    res.target = bdio_pkg::TGT_EXT;
                                    res.op     = bdio_pkg::XOP_TRACE;
                                    res.val    = {17'd0, cmd.data};
                                end
                                default: begin
                                    res.target = bdio_pkg::TGT_BAD;
                                    res.fault  = 1'b1;
                                end
                            endcase
                        end else if (!cmd.dbg) begin
                            unique case (io_reg)
                                IO_TICK: begin
                                    res.rdata = r_tick;
                                    n_tick    = 8'd0;
                                    n_irq     = 1'b0;
                                end
                                IO_WINDOW: res.rdata = r_window;
                                IO_CON: begin
                                    res.target = bdio_pkg::TGT_EXT;
                                    res.op     = bdio_pkg::XOP_CON_IN;
                                end
                                IO_CSTAT: begin
                                    res.target = bdio_pkg::TGT_EXT;
                                    res.op     = bdio_pkg::XOP_CON_STAT;
                                end
                                IO_KEY: begin
                                    res.rdata = r_key;
                                    n_key     = bdio_pkg::KEY_EMPTY;
                                end
                                IO_KHELD: begin
                                    res.rdata = (r_key == bdio_pkg::KEY_EMPTY) ? 8'd0 : 8'd1;
                                end
                                IO_DSEL:   res.rdata = {5'd0, r_dsel};
                                IO_BLK_HI: res.rdata = r_block[15:8];
                                IO_BLK_LO: res.rdata = r_block[7:0];
                                IO_DDATA: begin
                                    if (sel_ok) begin
                                        res.target = bdio_pkg::TGT_EXT;
                                        res.op     = bdio_pkg::XOP_DISK_RD;
                                    end else begin
                                        n_status = STAT_NODISK;
                                    end
                                end
                                IO_DSTAT: begin
                                    res.rdata = {6'd0, r_status};
                                    n_status  = 2'd0;
                                end
                                default: begin
                                    res.target = bdio_pkg::TGT_BAD;
                                    res.fault  = 1'b1;
                                end
                            endcase
                        end
                    end
                    default: begin
                        // Beyond RAM: a debug read is reported but does not fault.
                        res.target = bdio_pkg::TGT_BAD;
                        res.fault  = (cmd.kind == bdio_pkg::K_WRITE) || !cmd.dbg;
                    end
                endcase
            end
        endcase

        res.irq = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_buf[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= bdio_pkg::MASK_INIT;
            r_tick   <= '0;
            r_irq    <= 1'b0;
            r_window <= bdio_pkg::WINDOW_INIT;
            r_dsel   <= '0;
            r_block  <= '0;
            r_status <= '0;
            r_key    <= bdio_pkg::KEY_EMPTY;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            if (fire) begin
                r_tick   <= n_tick;
                r_irq    <= n_irq;
                r_window <= n_window;
                r_dsel   <= n_dsel;
                r_block  <= n_block;
                r_status <= n_status;
                r_key    <= n_key;
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (fire && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !fire) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/bus_decode_and_io_registers.sv
// ----------------------------------------------------------------------------
// bus_decode_and_io_registers
// Bus decoder and I/O register block of a small 24-bit CPU system.
// ----------------------------------------------------------------------------
// The block takes one item per clock while full is low (CPU read, CPU write,
// timer tick or typed key) and returns exactly one result per item, in order.
// An item pushed into the command queue is executed from the queue head once
// the result buffer has room, and its result waits in that buffer until popped.
// Throughput is one item per cycle while the result buffer has room, set by
// the execute unit that updates the I/O registers. A four-entry command queue
// sits between the address classifier and that unit, and a two-entry result
// buffer sits after it, so either side can stall without blocking the other;
// full rises only when four items wait for execution. Bank FF accesses go to
// the I/O page through the window register, resolved at execution time so
// that a window write takes effect for the very next item. The disk-present
// mask is written through its own channel, which is always ready; write it
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_decode_and_io_registers (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,

    input  wire logic           push,
    output logic                full,
    input  wire logic [1:0]     i_command,
    input  wire logic [23:0]    i_address,
    input  wire logic [7:0]     i_write_data,
    input  wire logic           i_debug_access,

    output logic                empty,
    input  wire logic           pop,
    output logic [2:0]          o_target,
    output logic [23:0]         o_mapped_address,
    output logic [7:0]          o_read_data,
    output logic [3:0]          o_ext_op,
    output logic [24:0]         o_ext_value,
    output logic                o_irq_level,
    output logic                o_fault,

    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_data
);

    bdio_pkg::t_cmd  cmd;
    bdio_pkg::t_head head;
    bdio_pkg::t_res  res;
    logic            take;

    // The mask register takes every write, so the channel never stalls.
    assign o_cfg_ready = 1'b1;

    bdio_front u_front (
        .i_command      (i_command),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_debug_access (i_debug_access),
        .o_cmd          (cmd)
    );

    bdio_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .o_head  (head),
        .i_take  (take)
    );

    bdio_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_take     (take),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    // The oldest buffered result drives the result ports directly.
    assign o_target         = res.target;
    assign o_mapped_address = res.maddr;
    assign o_read_data      = res.rdata;
    assign o_ext_op         = res.op;
    assign o_ext_value      = res.val;
    assign o_irq_level      = res.irq;
    assign o_fault          = res.fault;

endmodule

`default_nettype wire

>>> rtl/bdio_checker.sv
// ----------------------------------------------------------------------------
// bdio_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bdio_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           empty,
    input  wire logic           pop,
    input  wire logic [2:0]     o_target,
    input  wire logic [23:0]    o_mapped_address,
    input  wire logic [7:0]     o_read_data,
    input  wire logic [3:0]     o_ext_op,
    input  wire logic [24:0]    o_ext_value,
    input  wire logic           o_irq_level,
    input  wire logic           o_fault
);

    // A waiting result stays put until it is transferred.
    `ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(o_target) && $stable(o_mapped_address) && $stable(o_read_data) && $stable(o_ext_op) && $stable(o_ext_value) && $stable(o_irq_level) && $stable(o_fault))

    // An external request always names its operation, and only then.
    `ASSERT_IMPL(a_ext_op, !empty, (o_target == bdio_pkg::TGT_EXT) == (o_ext_op != bdio_pkg::XOP_NONE))

    // A fault is only raised on an invalid access.
    `ASSERT_IMPL(a_fault_bad, !empty && o_fault, o_target == bdio_pkg::TGT_BAD)

    // Video offsets stay inside the 16 KB window.
    `ASSERT_IMPL(a_vram_range, !empty && o_target == bdio_pkg::TGT_VRAM, o_mapped_address[23:14] == 10'd0)

endmodule

bind bus_decode_and_io_registers bdio_checker u_bdio_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_target         (o_target),
    .o_mapped_address (o_mapped_address),
    .o_read_data      (o_read_data),
    .o_ext_op         (o_ext_op),
    .o_ext_value      (o_ext_value),
    .o_irq_level      (o_irq_level),
    .o_fault          (o_fault)
);

`default_nettype wire
